/* src/fdcs_pkg.sv */
// ----------------------------------------------------------------------------
// fdcs_pkg - shared definitions for the filled disk column span rasteriser
// Field widths, configuration register indexes and limits, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fdcs_pkg;

    // Field widths
    localparam int COORD_W  = 12;
    localparam int RADIUS_W = 5;
    localparam int COLOR_W  = 8;
    localparam int COL_W    = 13;
    localparam int ROW_W    = 11;
    localparam int OFFSET_W = 22;
    localparam int SCREEN_W = 12;
    localparam int CFG_IDX_W = 8;

    // Largest radius handled; larger requests saturate here
    localparam logic [RADIUS_W-1:0] MAX_RADIUS = 5'd31;

    // Screen size clamp and reset values
    localparam logic [SCREEN_W-1:0] SCREEN_LIMIT = 12'd2048;
    localparam logic [SCREEN_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [SCREEN_W-1:0] HEIGHT_RESET = 12'd480;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic start_col;
        logic root_step;
        logic do_clip;
        logic do_mult;
        logic emit;
        logic next_col;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic root_done;
        logic last_col;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* src/fdcs_cfg.sv */
// ----------------------------------------------------------------------------
// fdcs_cfg - screen size configuration registers
// Holds screen width and height, clamped to the screen limit on write.
// Writes to indexes outside the register list are accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcs_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fdcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fdcs_pkg::SCREEN_W-1:0]  cfg_data,
    output logic [fdcs_pkg::SCREEN_W-1:0]       screen_width,
    output logic [fdcs_pkg::SCREEN_W-1:0]       screen_height
);
    import fdcs_pkg::*;

    logic [SCREEN_W-1:0] width_reg;
    logic [SCREEN_W-1:0] width_next;
    logic [SCREEN_W-1:0] height_reg;
    logic [SCREEN_W-1:0] height_next;
    logic [SCREEN_W-1:0] clamped;
    logic                wr_en;

    // Always take a configuration beat
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Clamp the written size to the screen limit
    assign clamped = (cfg_data > SCREEN_LIMIT) ? SCREEN_LIMIT : cfg_data;

    // Decode the register index
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en && (cfg_index == CFG_SCREEN_WIDTH))
        begin
            width_next = clamped;
        end
        if (wr_en && (cfg_index == CFG_SCREEN_HEIGHT))
        begin
            height_next = clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign screen_width  = width_reg;
    assign screen_height = height_reg;

endmodule

`default_nettype wire

/* src/fdcs_ctrl.sv */
// ----------------------------------------------------------------------------
// fdcs_ctrl - column scan sequencer
// One-hot state machine that steps the datapath through each column of the
// bounding square: set up, integer square root, clip, offset multiply, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fdcs_pkg::status_t status,
    output fdcs_pkg::cmd_t         cmd
);
    import fdcs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_COL  = 6'b000010,
        ST_ROOT = 6'b000100,
        ST_CLIP = 6'b001000,
        ST_MULT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_COL;
                end
            end
            ST_COL:
            begin
                cmd.start_col = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (status.root_done)
                begin
                    state_next = ST_CLIP;
                end
                else
                begin
                    cmd.root_step = 1'b1;
                end
            end
            ST_CLIP:
            begin
                cmd.do_clip = 1'b1;
                state_next  = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.do_mult = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_col = 1'b1;
                        state_next   = ST_COL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/fdcs_dpath.sv */
// ----------------------------------------------------------------------------
// fdcs_dpath - column span datapath
// Holds the circle command, runs the incremental integer square root for the
// half height of each column, clips the run to the screen, forms the
// framebuffer offset and keeps the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcs_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fdcs_pkg::cmd_t                cmd,
    output fdcs_pkg::status_t                  status,
    input  wire logic [fdcs_pkg::COORD_W-1:0]  center_x,
    input  wire logic [fdcs_pkg::COORD_W-1:0]  center_y,
    input  wire logic [fdcs_pkg::RADIUS_W-1:0] radius_px,
    input  wire logic [fdcs_pkg::COLOR_W-1:0]  fill_color,
    input  wire logic [fdcs_pkg::SCREEN_W-1:0] screen_width,
    input  wire logic [fdcs_pkg::SCREEN_W-1:0] screen_height,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fdcs_pkg::COL_W-1:0]         span_column,
    output logic [fdcs_pkg::ROW_W-1:0]         span_first_row,
    output logic [fdcs_pkg::ROW_W-1:0]         span_last_row,
    output logic [fdcs_pkg::OFFSET_W-1:0]      first_offset,
    output logic [fdcs_pkg::COLOR_W-1:0]       span_color,
    output logic                               span_empty,
    output logic                               span_final
);
    import fdcs_pkg::*;

    // Command registers
    logic signed [COORD_W-1:0]  cx_reg;
    logic signed [COORD_W-1:0]  cy_reg;
    logic [RADIUS_W-1:0]        r_reg;
    logic [COLOR_W-1:0]         color_reg;
    logic signed [RADIUS_W+1:0] dx_reg;
    logic signed [RADIUS_W+1:0] dx_next;

    // Square root iteration: t_reg tracks (h_reg + 1) squared
    logic [2*RADIUS_W-1:0] rem_reg;
    logic [RADIUS_W-1:0]   h_reg;
    logic [2*RADIUS_W:0]   t_reg;

    // Clipped column registers
    logic signed [COL_W-1:0] col_reg;
    logic [ROW_W-1:0]        lo_reg;
    logic [ROW_W-1:0]        hi_reg;
    logic                    empty_reg;
    logic [OFFSET_W-1:0]     prod_reg;

    // Output register
    logic                    out_valid_reg;
    logic [COL_W-1:0]        o_col_reg;
    logic [ROW_W-1:0]        o_first_reg;
    logic [ROW_W-1:0]        o_last_reg;
    logic [OFFSET_W-1:0]     o_offset_reg;
    logic [COLOR_W-1:0]      o_color_reg;
    logic                    o_empty_reg;
    logic                    o_final_reg;

    logic [RADIUS_W-1:0]     r_sat;
    logic [RADIUS_W+1:0]     dx_abs;
    logic [2*RADIUS_W-1:0]   r_sq;
    logic [2*RADIUS_W-1:0]   dx_sq;
    logic signed [COL_W-1:0] col_c;
    logic signed [COL_W:0]   lo_raw;
    logic signed [COL_W:0]   hi_raw;
    logic signed [COL_W:0]   lo_c;
    logic signed [COL_W:0]   hi_c;
    logic signed [COL_W:0]   row_max;
    logic                    empty_c;
    logic [OFFSET_W:0]       prod_c;
    logic [OFFSET_W-1:0]     offset_c;
    logic                    last_col;

    // Saturate the radius
    assign r_sat = (radius_px > MAX_RADIUS) ? MAX_RADIUS : radius_px;

    // Squares for the remaining budget of this column
    assign dx_abs = dx_reg[RADIUS_W+1] ? (RADIUS_W+2)'(-dx_reg) : dx_reg;
    assign r_sq   = {{RADIUS_W{1'b0}}, r_reg} * {{RADIUS_W{1'b0}}, r_reg};
    assign dx_sq  = {{(RADIUS_W-1){1'b0}}, dx_abs[RADIUS_W:0]}
                  * {{(RADIUS_W-1){1'b0}}, dx_abs[RADIUS_W:0]};

    assign last_col = (dx_reg == $signed({2'b00, r_reg}));

    // Column and clipped row run
    assign col_c   = $signed({cx_reg[COORD_W-1], cx_reg})
                   + $signed({{(COL_W-RADIUS_W-2){dx_reg[RADIUS_W+1]}}, dx_reg});
    assign lo_raw  = $signed({{2{cy_reg[COORD_W-1]}}, cy_reg})
                   - $signed({{(COL_W+1-RADIUS_W){1'b0}}, h_reg});
    assign hi_raw  = $signed({{2{cy_reg[COORD_W-1]}}, cy_reg})
                   + $signed({{(COL_W+1-RADIUS_W){1'b0}}, h_reg});
    assign row_max = $signed({2'b00, screen_height}) - $signed(14'sd1);
    assign lo_c    = lo_raw[COL_W] ? '0 : lo_raw;
    assign hi_c    = (hi_raw > row_max) ? row_max : hi_raw;
    assign empty_c = col_c[COL_W-1]
                   || (col_c >= $signed({1'b0, screen_width}))
                   || (lo_c > hi_c);

    // Row stride product and final offset
    assign prod_c   = {{(OFFSET_W+1-SCREEN_W){1'b0}}, screen_width}
                    * {{(OFFSET_W+1-ROW_W){1'b0}}, lo_reg};
    assign offset_c = empty_reg ? '0
                    : prod_reg + {{(OFFSET_W-COL_W){col_reg[COL_W-1]}}, col_reg};

    assign dx_next = dx_reg + (RADIUS_W+2)'(1);

    // Command, scan and square root registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= '0;
            dx_reg  <= '0;
            rem_reg <= '0;
            h_reg   <= '0;
            t_reg   <= (2*RADIUS_W+1)'(1);
        end
        else
        begin
            if (cmd.load_item)
            begin
                r_reg  <= r_sat;
                dx_reg <= -$signed({2'b00, r_sat});
            end
            else if (cmd.next_col)
            begin
                dx_reg <= dx_next;
            end
            if (cmd.start_col)
            begin
                rem_reg <= r_sq - dx_sq;
                h_reg   <= '0;
                t_reg   <= (2*RADIUS_W+1)'(1);
            end
            else if (cmd.root_step)
            begin
                h_reg <= h_reg + RADIUS_W'(1);
                t_reg <= t_reg + (2*RADIUS_W+1)'({h_reg, 1'b0})
                       + (2*RADIUS_W+1)'(3);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cx_reg    <= $signed(center_x);
            cy_reg    <= $signed(center_y);
            color_reg <= fill_color;
        end
        if (cmd.do_clip)
        begin
            col_reg   <= col_c;
            empty_reg <= empty_c;
            lo_reg    <= empty_c ? '0 : lo_c[ROW_W-1:0];
            hi_reg    <= empty_c ? '0 : hi_c[ROW_W-1:0];
        end
        if (cmd.do_mult)
        begin
            prod_reg <= prod_c[OFFSET_W-1:0];
        end
        if (cmd.emit)
        begin
            o_col_reg    <= col_reg;
            o_first_reg  <= lo_reg;
            o_last_reg   <= hi_reg;
            o_offset_reg <= offset_c;
            o_color_reg  <= color_reg;
            o_empty_reg  <= empty_reg;
            o_final_reg  <= last_col;
        end
    end

    // Output beat valid: set on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.root_done = (t_reg > {1'b0, rem_reg});
    assign status.last_col  = last_col;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign span_column    = o_col_reg;
    assign span_first_row = o_first_reg;
    assign span_last_row  = o_last_reg;
    assign first_offset   = o_offset_reg;
    assign span_color     = o_color_reg;
    assign span_empty     = o_empty_reg;
    assign span_final     = o_final_reg;

    // The root iteration keeps t equal to (h + 1) squared
    a_root_invariant: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg == ({6'b0, h_reg} + 11'd1) * ({6'b0, h_reg} + 11'd1))
        else $error("root iteration lost its square");

    // The scan never passes the right edge of the bounding square
    a_dx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dx_reg <= $signed({2'b00, r_reg}))
        else $error("column offset beyond radius");

    // A non-empty clipped run is ordered
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_clip |=> (empty_reg || (lo_reg <= hi_reg)))
        else $error("clipped run out of order");

    // The last column leaves a final beat in the output register
    a_final_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && last_col) |=> (out_valid_reg && o_final_reg))
        else $error("final column not flagged");

endmodule

`default_nettype wire

/* src/filled_disk_column_spans.sv */
// ----------------------------------------------------------------------------
// filled_disk_column_spans - filled circle to column span rasteriser
// Scans the bounding square of a filled circle column by column and gives
// one clipped row span per column, with its framebuffer offset.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    center_x, center_y, radius_px,
//                                              fill_color
//   out      source     out_valid / out_ready  span_column, span_first_row,
//                                              span_last_row, first_offset,
//                                              span_color, span_empty,
//                                              span_final
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A circle of radius r gives 2r+1 beats. Each column steps through set up,
// the square root, clip, offset multiply and emit; h, the column's half
// height (0..r), is set by the one-step-per-cycle square root iteration.
// The next circle is taken once the last column is in the output register.
// A stalled output holds the sequencer in its emit step.
// Reset sets the screen to 640 by 480 and leaves the block idle.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_disk_column_spans (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [fdcs_pkg::COORD_W-1:0]   center_x,
    input  wire logic [fdcs_pkg::COORD_W-1:0]   center_y,
    input  wire logic [fdcs_pkg::RADIUS_W-1:0]  radius_px,
    input  wire logic [fdcs_pkg::COLOR_W-1:0]   fill_color,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [fdcs_pkg::COL_W-1:0]          span_column,
    output logic [fdcs_pkg::ROW_W-1:0]          span_first_row,
    output logic [fdcs_pkg::ROW_W-1:0]          span_last_row,
    output logic [fdcs_pkg::OFFSET_W-1:0]       first_offset,
    output logic [fdcs_pkg::COLOR_W-1:0]        span_color,
    output logic                                span_empty,
    output logic                                span_final,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fdcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fdcs_pkg::SCREEN_W-1:0]  cfg_data
);
    import fdcs_pkg::*;

    cmd_t                cmd;
    status_t             status;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;

    // Screen size registers
    fdcs_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .screen_width  (screen_width),
        .screen_height (screen_height)
    );

    // Sequencer
    fdcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    fdcs_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius_px      (radius_px),
        .fill_color     (fill_color),
        .screen_width   (screen_width),
        .screen_height  (screen_height),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .span_column    (span_column),
        .span_first_row (span_first_row),
        .span_last_row  (span_last_row),
        .first_offset   (first_offset),
        .span_color     (span_color),
        .span_empty     (span_empty),
        .span_final     (span_final)
    );

endmodule

`default_nettype wire
